// ----- rtl/core/trapezoid_integrator_coning_defines.svh -----
// assertion macros used by the integrator sequencer
`ifndef TRAPEZOID_INTEGRATOR_CONING_DEFINES_SVH
`define TRAPEZOID_INTEGRATOR_CONING_DEFINES_SVH

// condition holds in the same cycle
`define TIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define TIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tic_pkg.sv -----
// shared constants, types and saturating arithmetic of the rate integrator
`default_nettype none

package tic_pkg;

    // field and accumulator widths
    localparam int SMP_W     = 32;
    localparam int ACC_W     = 64;
    localparam int DT_W      = 24;
    localparam int TIME_W    = 64;
    localparam int SPAN_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int AXES      = 3;
    localparam int AX_W      = 2;
    localparam int HALF_W    = ACC_W / 2;

    // rate sum magnitude and rate times dt product
    localparam int MAG_W   = SMP_W + 1;
    localparam int PROD_W  = MAG_W + DT_W;

    // conversion of q16 times us into q32 times s: (p * 512 + 7812) / 15625
    localparam int DQ_SCALE_SH = 9;
    localparam int DQ_W        = PROD_W + DQ_SCALE_SH + 1;
    localparam int DQ_DV_W     = 14;
    localparam logic [DQ_DV_W-1:0] DQ_DIVISOR = DQ_DV_W'(15625);
    localparam int DQ_ROUND    = 7812;

    // rounded division by six
    localparam int D6_W    = ACC_W + 1;
    localparam int D6_DV_W = 3;
    localparam logic [D6_DV_W-1:0] D6_DIVISOR = D6_DV_W'(6);
    localparam int D6_ROUND = 3;

    // shared multiplier
    localparam int MUL_A_W = MAG_W;
    localparam int MUL_B_W = HALF_W;
    localparam int MUL_O_W = MUL_A_W + MUL_B_W;
    localparam int PP_W    = 2 * ACC_W;
    localparam int MS_SH   = 33;

    // output rounding from q32 to q16
    localparam int Q16_SH  = 16;
    localparam int Q16_RND = 1 << (Q16_SH - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CONING   = CFG_IDX_W'(1);

    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [DT_W-1:0]  DT_MAX  = '1;
    localparam logic [SMP_W-1:0] OUT_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0] OUT_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_DELTA,
        S_LEVER,
        S_PMUL,
        S_PACC,
        S_PFIN,
        S_CSUB,
        S_BETA,
        S_COMMIT,
        S_TOTAL,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic            in_ready;
        logic            first_commit;
        logic            load_diff;
        logic            mul_dt;
        logic [AX_W-1:0] axis;
        logic            div_start;
        logic            delta_load;
        logic            lever_load;
        logic            pp_mul;
        logic [1:0]      pidx;
        logic [2:0]      prod;
        logic            pp_fin;
        logic            csub;
        logic            beta_upd;
        logic            commit;
        logic            total_load;
        logic            emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic is_first;
        logic div_done;
        logic coning;
        logic fire;
        logic out_free;
    } t_stat;

    function automatic t_acc sat_add(input t_acc a, input t_acc b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    function automatic t_acc sat_sub(input t_acc a, input t_acc b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    // magnitude plus sign to saturated signed value
    function automatic t_acc signed_sat(input logic [DQ_W-1:0] m, input logic neg);
        t_acc v;
        v = m[ACC_W-1:0];
        if (m > DQ_W'(ACC_MAX)) return neg ? ACC_MIN : ACC_MAX;
        return neg ? -v : v;
    endfunction

    function automatic logic [ACC_W-1:0] magn(input t_acc v);
        return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

    // round to nearest, ties away from zero, saturate to the sample range
    function automatic logic [SMP_W-1:0] to_q16(input t_acc v);
        logic [ACC_W:0] m;
        logic [ACC_W:0] q;
        m = {1'b0, magn(v)} + (ACC_W+1)'(Q16_RND);
        q = m >> Q16_SH;
        if (q > (ACC_W+1)'(OUT_MAX)) return v[ACC_W-1] ? OUT_MIN : OUT_MAX;
        return v[ACC_W-1] ? (~q[SMP_W-1:0] + 1'b1) : q[SMP_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tic_in_if.sv -----
// rate sample channel
`default_nettype none

interface tic_in_if
    import tic_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        sample_time;
    logic signed [SMP_W-1:0]  rate_x;
    logic signed [SMP_W-1:0]  rate_y;
    logic signed [SMP_W-1:0]  rate_z;

    modport source (output valid, sample_time, rate_x, rate_y, rate_z, input ready);
    modport sink   (input valid, sample_time, rate_x, rate_y, rate_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tic_out_if.sv -----
// integral result channel
`default_nettype none

interface tic_out_if
    import tic_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  integral_x;
    logic signed [SMP_W-1:0]  integral_y;
    logic signed [SMP_W-1:0]  integral_z;
    logic [SPAN_W-1:0]        span_us;

    modport source (output valid, integral_x, integral_y, integral_z, span_us, input ready);
    modport sink   (input valid, integral_x, integral_y, integral_z, span_us, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tic_div.sv -----
// long division by a constant, sixteen quotient bits per cycle by reciprocal multiplication
`default_nettype none

module tic_div
    import tic_pkg::*;
#(
    parameter int               W       = DQ_W,
    parameter int               DV_W    = DQ_DV_W,
    parameter logic [DV_W-1:0]  DIVISOR = DQ_DIVISOR
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_dividend,
    output logic [W-1:0]  o_quotient,
    output logic          o_busy
);
    // dividend chunks and the exact reciprocal for one chunk step
    localparam int DG_W  = 16;
    localparam int NCH   = (W + DG_W - 1) / DG_W;
    localparam int PW    = NCH * DG_W;
    localparam int N_W   = DV_W + DG_W;
    localparam int K_SH  = N_W + DV_W;
    localparam int M_W   = N_W + 1;
    localparam int P_W   = N_W + M_W;
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << K_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam int CNT_W = $clog2(NCH + 1);

    logic [PW-1:0]    r_q;
    logic [DV_W-1:0]  r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   num;
    logic [P_W-1:0]   prod;
    logic [DG_W-1:0]  qd;
    logic [N_W-1:0]   back;
    logic [N_W-1:0]   rem_full;

    // one quotient digit from remainder and next chunk
    always_comb begin
        num      = {r_rem, r_q[PW-1 -: DG_W]};
        prod     = P_W'(num) * P_W'(RECIP);
        qd       = prod[K_SH +: DG_W];
        back     = N_W'(qd) * N_W'(DIVISOR);
        rem_full = num - back;
    end

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NCH);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // remainder and chunk shift register, quotient digits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= PW'(i_dividend);
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[PW-DG_W-1:0], qd};
            r_rem <= rem_full[DV_W-1:0];
        end
    end

    assign o_quotient = r_q[W-1:0];
    assign o_busy     = r_cnt != '0;
endmodule

`default_nettype wire

// ----- rtl/core/tic_ctrl.sv -----
// sequencer of the integrator: one sample at a time through the datapath
`default_nettype none
`include "trapezoid_integrator_coning_defines.svh"

module tic_ctrl
    import tic_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state          r_state, n_state;
    logic [AX_W-1:0] r_axis, n_axis;
    logic [1:0]      r_pidx, n_pidx;
    logic [2:0]      r_prod, n_prod;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_stat.in_valid) n_state = S_CHECK;
            S_CHECK:     n_state = i_stat.is_first ? S_IDLE : S_MUL;
            S_MUL:       if (r_axis == AX_W'(AXES - 1)) n_state = S_DIV_START;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT:  if (i_stat.div_done) n_state = S_DELTA;
            S_DELTA:     n_state = i_stat.coning ? S_LEVER : S_COMMIT;
            S_LEVER:     n_state = S_PMUL;
            S_PMUL:      if (r_pidx == 2'd3) n_state = S_PACC;
            S_PACC:      n_state = S_PFIN;
            S_PFIN:      n_state = r_prod[0] ? S_CSUB : S_PMUL;
            S_CSUB:      n_state = S_BETA;
            S_BETA:      n_state = (r_prod == 3'd5) ? S_COMMIT : S_PMUL;
            S_COMMIT:    n_state = S_TOTAL;
            S_TOTAL:     n_state = S_EMIT;
            S_EMIT:      if (!i_stat.fire || i_stat.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // axis, partial product and product counters
    always_comb begin
        n_axis = (r_state == S_MUL) ? r_axis + 1'b1 : '0;
        n_pidx = (r_state == S_PMUL) ? r_pidx + 1'b1 : '0;
        n_prod = r_prod;
        if (r_state == S_LEVER) begin
            n_prod = '0;
        end else if ((r_state == S_PFIN && !r_prod[0]) || r_state == S_BETA) begin
            n_prod = r_prod + 1'b1;
        end
    end

    // command outputs
    always_comb begin
        o_cmd              = '0;
        o_cmd.axis         = r_axis;
        o_cmd.pidx         = r_pidx;
        o_cmd.prod         = r_prod;
        o_cmd.in_ready     = r_state == S_IDLE;
        o_cmd.first_commit = r_state == S_CHECK && i_stat.is_first;
        o_cmd.load_diff    = r_state == S_CHECK;
        o_cmd.mul_dt       = r_state == S_MUL;
        o_cmd.div_start    = r_state == S_DIV_START;
        o_cmd.delta_load   = r_state == S_DELTA;
        o_cmd.lever_load   = r_state == S_LEVER;
        o_cmd.pp_mul       = r_state == S_PMUL;
        o_cmd.pp_fin       = r_state == S_PFIN;
        o_cmd.csub         = r_state == S_CSUB;
        o_cmd.beta_upd     = r_state == S_BETA;
        o_cmd.commit       = r_state == S_COMMIT;
        o_cmd.total_load   = r_state == S_TOTAL;
        o_cmd.emit         = r_state == S_EMIT && i_stat.fire && i_stat.out_free;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_pidx  <= '0;
            r_prod  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_pidx  <= n_pidx;
            r_prod  <= n_prod;
        end
    end

    `TIC_ASSERT_NEXT(a_accept_starts, r_state == S_IDLE && i_stat.in_valid, r_state == S_CHECK, "accepted sample not taken up")
    `TIC_ASSERT_NEXT(a_first_returns, r_state == S_CHECK && i_stat.is_first, r_state == S_IDLE, "first sample did not finish at once")
    `TIC_ASSERT_NEXT(a_div_to_delta, r_state == S_DIV_WAIT && i_stat.div_done, r_state == S_DELTA, "divider result not consumed")
    `TIC_ASSERT_NEXT(a_emit_holds, r_state == S_EMIT && i_stat.fire && !i_stat.out_free, r_state == S_EMIT && !o_cmd.in_ready, "result dropped on stalled output")
    `TIC_ASSERT_NOW(a_prod_range, r_state == S_PMUL || r_state == S_PFIN, r_prod <= 3'd5, "coning product index out of range")
endmodule

`default_nettype wire

// ----- rtl/core/tic_dp.sv -----
// integrator datapath: state, shared multiplier, dividers and output register
`default_nettype none

module tic_dp
    import tic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tic_in_if.sink               i_smp,
    tic_out_if.source            o_res,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);
    // configuration
    logic [CFG_W-1:0]  r_interval;
    logic              r_coning;

    // architectural state
    logic [TIME_W-1:0] r_last_time;
    logic [TIME_W-1:0] r_reset_time;
    logic [SMP_W-1:0]  r_prev_rate [AXES];
    t_acc              r_alpha [AXES];
    t_acc              r_beta [AXES];
    t_acc              r_prev_alpha [AXES];
    t_acc              r_prev_delta [AXES];

    // working registers of one sample
    logic [TIME_W-1:0] r_t;
    logic [SMP_W-1:0]  r_rate [AXES];
    logic [DT_W-1:0]   r_dt;
    logic [MAG_W-1:0]  r_mag [AXES];
    logic              r_sneg [AXES];
    logic [PROD_W-1:0] r_p [AXES];
    t_acc              r_delta [AXES];
    t_acc              r_d6 [AXES];
    t_acc              r_lever [AXES];
    logic [2*HALF_W-1:0] r_mp;
    logic              r_mp_vld;
    logic [1:0]        r_mp_sh;
    logic [PP_W-1:0]   r_pp;
    t_acc              r_t0, r_t1, r_c;
    t_acc              r_total [AXES];
    logic              r_fire;
    logic [SPAN_W-1:0] r_span;

    // output register
    logic              r_ovld;
    logic [SMP_W-1:0]  r_oint [AXES];
    logic [SPAN_W-1:0] r_ospan;

    logic [SMP_W-1:0]  in_rate [AXES];
    logic [TIME_W-1:0] dt_diff;
    logic [TIME_W-1:0] elapsed;
    logic [MAG_W-1:0]  rsum [AXES];

    logic [DQ_W-1:0]   dq_num [AXES];
    logic [DQ_W-1:0]   dq_quo [AXES];
    logic [D6_W-1:0]   d6_num [AXES];
    logic [D6_W-1:0]   d6_quo [AXES];
    logic [AXES-1:0]   dq_busy, d6_busy;

    t_acc              lev_sel, del_sel;
    logic [ACC_W-1:0]  lev_mag, del_mag;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_O_W-1:0] mul_out;
    logic [1:0]        sh_cnt;
    logic [PP_W-1:0]   pp_add;
    logic [PP_W-1:0]   pp_sum;
    logic [ACC_W-1:0]  pp_m;
    t_acc              pp_val;

    assign in_rate[0] = i_smp.rate_x;
    assign in_rate[1] = i_smp.rate_y;
    assign in_rate[2] = i_smp.rate_z;

    // time difference and rate sums for the trapezoid
    always_comb begin
        dt_diff = r_t - r_last_time;
        elapsed = r_t - r_reset_time;
        for (int i = 0; i < AXES; i++) begin
            rsum[i] = {r_rate[i][SMP_W-1], r_rate[i]}
                    + {r_prev_rate[i][SMP_W-1], r_prev_rate[i]};
        end
    end

    // divider lanes: delta scaling and lever division by six
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        assign dq_num[g] = {1'b0, r_p[g], {DQ_SCALE_SH{1'b0}}} + DQ_W'(DQ_ROUND);
        assign d6_num[g] = {1'b0, magn(r_prev_delta[g])} + D6_W'(D6_ROUND);

        tic_div #(.W(DQ_W), .DV_W(DQ_DV_W), .DIVISOR(DQ_DIVISOR)) u_dq (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.div_start),
            .i_dividend (dq_num[g]),
            .o_quotient (dq_quo[g]),
            .o_busy     (dq_busy[g])
        );

        tic_div #(.W(D6_W), .DV_W(D6_DV_W), .DIVISOR(D6_DIVISOR)) u_d6 (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.div_start),
            .i_dividend (d6_num[g]),
            .o_quotient (d6_quo[g]),
            .o_busy     (d6_busy[g])
        );
    end

    // operand pair of the current coning product
    always_comb begin
        lev_sel = r_lever[0];
        del_sel = r_delta[0];
        case (i_cmd.prod)
            3'd0: begin lev_sel = r_lever[1]; del_sel = r_delta[2]; end
            3'd1: begin lev_sel = r_lever[2]; del_sel = r_delta[1]; end
            3'd2: begin lev_sel = r_lever[2]; del_sel = r_delta[0]; end
            3'd3: begin lev_sel = r_lever[0]; del_sel = r_delta[2]; end
            3'd4: begin lev_sel = r_lever[0]; del_sel = r_delta[1]; end
            3'd5: begin lev_sel = r_lever[1]; del_sel = r_delta[0]; end
            default: ;
        endcase
        lev_mag = magn(lev_sel);
        del_mag = magn(del_sel);
    end

    // shared multiplier operands
    always_comb begin
        mul_a = MUL_A_W'(i_cmd.pidx[1] ? lev_mag[ACC_W-1:HALF_W] : lev_mag[HALF_W-1:0]);
        mul_b = i_cmd.pidx[0] ? del_mag[ACC_W-1:HALF_W] : del_mag[HALF_W-1:0];
        if (i_cmd.mul_dt) begin
            mul_b = MUL_B_W'(r_dt);
            for (int i = 0; i < AXES; i++) begin
                if (i_cmd.axis == AX_W'(i)) mul_a = r_mag[i];
            end
        end
    end

    assign mul_out = MUL_O_W'(mul_a) * MUL_O_W'(mul_b);

    // partial product alignment and product rounding
    always_comb begin
        sh_cnt = {1'b0, r_mp_sh[1]} + {1'b0, r_mp_sh[0]};
        pp_add = PP_W'(r_mp) << (sh_cnt * HALF_W);
        pp_sum = r_pp + (PP_W'(1) << (MS_SH - 1));
        pp_m   = (|pp_sum[PP_W-1:MS_SH+ACC_W]) ? '1 : pp_sum[MS_SH+ACC_W-1:MS_SH];
        pp_val = signed_sat(DQ_W'(pp_m), lev_sel[ACC_W-1] ^ del_sel[ACC_W-1]);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= '0;
            r_coning   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INTERVAL: r_interval <= i_cfg_data;
                CFG_CONING:   r_coning   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // architectural state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_reset_time <= '0;
            r_ovld       <= 1'b0;
            r_mp_vld     <= 1'b0;
            r_fire       <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_prev_rate[i]  <= '0;
                r_alpha[i]      <= '0;
                r_beta[i]       <= '0;
                r_prev_alpha[i] <= '0;
                r_prev_delta[i] <= '0;
            end
        end else begin
            r_mp_vld <= i_cmd.pp_mul;

            // first sample only records time and rates
            if (i_cmd.first_commit) begin
                r_last_time  <= r_t;
                r_reset_time <= r_t;
                for (int i = 0; i < AXES; i++) r_prev_rate[i] <= r_rate[i];
            end

            // coning accumulation for one axis
            if (i_cmd.beta_upd) begin
                for (int i = 0; i < AXES; i++) begin
                    if (i_cmd.prod[2:1] == 2'(i)) r_beta[i] <= sat_add(r_beta[i], r_c);
                end
            end

            // trapezoid step complete
            if (i_cmd.commit) begin
                r_last_time <= r_t;
                r_fire      <= (r_interval != '0) && (elapsed >= TIME_W'(r_interval));
                for (int i = 0; i < AXES; i++) begin
                    r_prev_rate[i] <= r_rate[i];
                    r_alpha[i]     <= sat_add(r_alpha[i], r_delta[i]);
                    if (r_coning) begin
                        r_prev_delta[i] <= r_delta[i];
                        r_prev_alpha[i] <= r_alpha[i];
                    end
                end
            end

            // auto reset with result
            if (i_cmd.emit) begin
                r_reset_time <= r_t;
                for (int i = 0; i < AXES; i++) begin
                    r_alpha[i]      <= '0;
                    r_prev_alpha[i] <= '0;
                    r_beta[i]       <= '0;
                end
            end

            if (i_cmd.emit) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_cmd.in_ready) begin
            r_t <= i_smp.sample_time;
            for (int i = 0; i < AXES; i++) r_rate[i] <= in_rate[i];
        end

        if (i_cmd.load_diff) begin
            if (r_t < r_last_time) begin
                r_dt <= '0;
            end else if (dt_diff > TIME_W'(DT_MAX)) begin
                r_dt <= DT_MAX;
            end else begin
                r_dt <= dt_diff[DT_W-1:0];
            end
            for (int i = 0; i < AXES; i++) begin
                r_sneg[i] <= rsum[i][MAG_W-1];
                r_mag[i]  <= rsum[i][MAG_W-1] ? -rsum[i] : rsum[i];
            end
        end

        if (i_cmd.mul_dt) begin
            for (int i = 0; i < AXES; i++) begin
                if (i_cmd.axis == AX_W'(i)) r_p[i] <= mul_out[PROD_W-1:0];
            end
        end

        if (i_cmd.delta_load) begin
            for (int i = 0; i < AXES; i++) begin
                r_delta[i] <= signed_sat(dq_quo[i], r_sneg[i]);
                r_d6[i]    <= signed_sat(DQ_W'(d6_quo[i]), r_prev_delta[i][ACC_W-1]);
            end
        end

        if (i_cmd.lever_load) begin
            for (int i = 0; i < AXES; i++) r_lever[i] <= sat_add(r_prev_alpha[i], r_d6[i]);
        end

        // partial products of one 64 by 64 magnitude product
        if (i_cmd.pp_mul) begin
            r_mp    <= mul_out[2*HALF_W-1:0];
            r_mp_sh <= i_cmd.pidx;
        end
        if (r_mp_vld) begin
            r_pp <= r_pp + pp_add;
        end else if (i_cmd.pp_mul) begin
            r_pp <= '0;
        end

        if (i_cmd.pp_fin) begin
            if (i_cmd.prod[0]) r_t1 <= pp_val;
            else               r_t0 <= pp_val;
        end

        if (i_cmd.csub) r_c <= sat_sub(r_t0, r_t1);

        if (i_cmd.commit) r_span <= elapsed[SPAN_W-1:0];

        if (i_cmd.total_load) begin
            for (int i = 0; i < AXES; i++) begin
                r_total[i] <= r_coning ? sat_add(r_alpha[i], r_beta[i]) : r_alpha[i];
            end
        end

        if (i_cmd.emit) begin
            r_ospan <= r_span;
            for (int i = 0; i < AXES; i++) r_oint[i] <= to_q16(r_total[i]);
        end
    end

    // channel outputs and status
    assign i_smp.ready      = i_cmd.in_ready;
    assign o_res.valid      = r_ovld;
    assign o_res.integral_x = r_oint[0];
    assign o_res.integral_y = r_oint[1];
    assign o_res.integral_z = r_oint[2];
    assign o_res.span_us    = r_ospan;

    always_comb begin
        o_stat.in_valid = i_smp.valid;
        o_stat.is_first = r_last_time == '0;
        o_stat.div_done = ~|{dq_busy, d6_busy};
        o_stat.coning   = r_coning;
        o_stat.fire     = r_fire;
        o_stat.out_free = !r_ovld || o_res.ready;
    end
endmodule

`default_nettype wire

// ----- rtl/core/trapezoid_integrator_coning.sv -----
// top level of the trapezoidal gyro integrator with coning correction
//
// Usage:
//   i_smp carries timestamped three-axis rate samples (q15.16, time in us);
//   o_res carries the saturated q15.16 integral and the span in us, once per
//   elapsed auto-reset interval. Both use valid/ready; a transaction happens
//   when both are high at a rising clock edge.
//   Configuration is a write port: i_cfg_idx 0 is the reset interval in us
//   (zero disables results), 1 is the coning enable. Write while idle.
// Sequence:
//   a first sample (recorded last sample time still zero) only records its
//   time and rates; other samples run the trapezoid step, with coning also the
//   six 64 by 64 coning products, and may wait for a held result to leave
//   the output register. The five-step long dividers (16 quotient bits a step)
//   and the coning products, built on one 33 by 32 multiplier over 4 partial
//   products each, pace the sample. A result leaves at the end of its sample.
// Reset: i_rst_n synchronous, active low; clears all state and configuration.
// Stall: the result sits in an output register; the next sample is accepted
//   meanwhile and only waits at its own result if the old one is still held.
`default_nettype none

module trapezoid_integrator_coning
    import tic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tic_in_if.sink               i_smp,
    tic_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    // sequencer
    tic_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath
    tic_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (i_smp),
        .o_res      (o_res),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );
endmodule

`default_nettype wire

// ----- tb/sv/trapezoid_integrator_coning_tb.sv -----
// testbench for the trapezoidal rate integrator with coning correction
`default_nettype none

module trapezoid_integrator_coning_tb
    import tic_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // one rate sample transaction
    typedef struct packed {
        logic [TIME_W-1:0]       sample_time;
        logic signed [SMP_W-1:0] rate_x;
        logic signed [SMP_W-1:0] rate_y;
        logic signed [SMP_W-1:0] rate_z;
    } t_sample;

    // one integral transaction
    typedef struct packed {
        logic signed [SMP_W-1:0] integral_x;
        logic signed [SMP_W-1:0] integral_y;
        logic signed [SMP_W-1:0] integral_z;
        logic [SPAN_W-1:0]       span_us;
    } t_integral;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    tic_in_if  smp_if ();
    tic_out_if res_if ();

    trapezoid_integrator_coning dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // golden integrator state
    logic [31:0] gold_interval;
    logic        gold_coning;
    logic [63:0] gold_last_time;
    logic [63:0] gold_reset_time;
    t_acc        gold_prev_rate [AXES];
    t_acc        gold_alpha [AXES];
    t_acc        gold_beta [AXES];
    t_acc        gold_prev_alpha [AXES];
    t_acc        gold_prev_delta [AXES];

    t_sample   pending_samples[$];
    t_integral expected_integrals[$];
    int        mismatch_count;
    int        idle_cycles;
    bit        timed_out;
    bit        send_enable;
    bit        in_accepted;
    int        burst_left;
    int        gap_left;
    int        stall_phase;
    int        stall_period;
    int        stall_len;

    // saturating helpers in the accumulator range
    function automatic t_acc acc_sat(input logic [127:0] m, input logic neg);
        if (m > 128'(ACC_MAX)) return neg ? ACC_MIN : ACC_MAX;
        return neg ? -t_acc'(m) : t_acc'(m);
    endfunction

    function automatic t_acc acc_add(input t_acc a, input t_acc b);
        logic signed [ACC_W:0] s;
        s = a + b;
        if (s > ACC_MAX) return ACC_MAX;
        if (s < ACC_MIN) return ACC_MIN;
        return t_acc'(s);
    endfunction

    function automatic t_acc acc_diff(input t_acc a, input t_acc b);
        logic signed [ACC_W:0] s;
        s = a - b;
        if (s > ACC_MAX) return ACC_MAX;
        if (s < ACC_MIN) return ACC_MIN;
        return t_acc'(s);
    endfunction

    function automatic logic [127:0] abs128(input t_acc v);
        logic signed [127:0] w;
        w = v;
        return w < 0 ? -w : w;
    endfunction

    // rounded product a * b / 2^33
    function automatic t_acc half_product(input t_acc a, input t_acc b);
        logic [127:0] p;
        p = (abs128(a) * abs128(b) + (128'd1 << 32)) >> 33;
        return acc_sat(p, (a < 0) != (b < 0));
    endfunction

    function automatic t_acc sixth(input t_acc v);
        return acc_sat((abs128(v) + 3) / 6, v < 0);
    endfunction

    function automatic logic [31:0] round_q16(input t_acc v);
        logic [127:0] m;
        m = (abs128(v) + 32768) >> 16;
        if (v < 0) return (m > 128'h8000_0000) ? 32'h8000_0000 : -m[31:0];
        return (m > 128'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
    endfunction

    task automatic gold_reset();
        gold_interval = '0;
        gold_coning = 1'b0;
        gold_last_time = '0;
        gold_reset_time = '0;
        for (int i = 0; i < AXES; i++) begin
            gold_prev_rate[i] = '0;
            gold_alpha[i] = '0;
            gold_beta[i] = '0;
            gold_prev_alpha[i] = '0;
            gold_prev_delta[i] = '0;
        end
    endtask

    // advance the golden integrator by one sample
    task automatic integrate_sample(input t_sample s);
        t_acc rate [AXES];
        t_acc delta [AXES];
        t_acc lever [AXES];
        t_acc sum;
        t_acc total;
        logic [127:0] p;
        logic [127:0] q;
        logic [63:0] dt;
        logic [63:0] span;
        t_integral r;
        int j;
        int k;
        rate[0] = s.rate_x;
        rate[1] = s.rate_y;
        rate[2] = s.rate_z;
        if (gold_last_time == 0) begin
            gold_last_time = s.sample_time;
            gold_reset_time = s.sample_time;
            for (int i = 0; i < AXES; i++) gold_prev_rate[i] = rate[i];
            return;
        end
        dt = 0;
        if (s.sample_time >= gold_last_time) begin
            dt = s.sample_time - gold_last_time;
            if (dt > 64'(DT_MAX)) dt = 64'(DT_MAX);
        end
        for (int i = 0; i < AXES; i++) begin
            sum = rate[i] + gold_prev_rate[i];
            p = abs128(sum) * dt;
            q = (p * 512 + 7812) / 15625;
            delta[i] = acc_sat(q, sum < 0);
            gold_prev_rate[i] = rate[i];
        end
        if (gold_coning) begin
            for (int i = 0; i < AXES; i++)
                lever[i] = acc_add(gold_prev_alpha[i], sixth(gold_prev_delta[i]));
            for (int i = 0; i < AXES; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                gold_beta[i] = acc_add(gold_beta[i],
                    acc_diff(half_product(lever[j], delta[k]),
                             half_product(lever[k], delta[j])));
            end
            for (int i = 0; i < AXES; i++) begin
                gold_prev_delta[i] = delta[i];
                gold_prev_alpha[i] = gold_alpha[i];
            end
        end
        for (int i = 0; i < AXES; i++) gold_alpha[i] = acc_add(gold_alpha[i], delta[i]);
        gold_last_time = s.sample_time;
        span = s.sample_time - gold_reset_time;
        if (gold_interval != 0 && span >= 64'(gold_interval)) begin
            for (int i = 0; i < AXES; i++) begin
                total = gold_coning ? acc_add(gold_alpha[i], gold_beta[i]) : gold_alpha[i];
                case (i)
                    0: r.integral_x = round_q16(total);
                    1: r.integral_y = round_q16(total);
                    default: r.integral_z = round_q16(total);
                endcase
                gold_alpha[i] = '0;
                gold_prev_alpha[i] = '0;
                gold_beta[i] = '0;
            end
            r.span_us = span[31:0];
            gold_reset_time = s.sample_time;
            expected_integrals.push_back(r);
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sender: bursts and gaps, inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
        end else if (smp_if.valid && !in_accepted) begin
            // hold the offered transaction
        end else begin
            if (smp_if.valid) burst_left = burst_left - 1;
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                smp_if.valid <= 1'b0;
            end else if (send_enable && pending_samples.size() > 0) begin
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                if (gap_left > 0) begin
                    smp_if.valid <= 1'b0;
                end else begin
                    smp_if.valid <= 1'b1;
                    {smp_if.sample_time, smp_if.rate_x, smp_if.rate_y, smp_if.rate_z}
                        <= pending_samples.pop_front();
                end
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        stall_phase = (stall_phase + 1) % stall_period;
        if (stall_phase == 0) begin
            stall_period = $urandom_range(4, 200);
            stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, stall_period - 1);
        end
        res_if.ready <= (stall_phase >= stall_len);
    end

    // monitor: predict on accepted samples, check accepted integrals
    always @(posedge i_clk) begin
        t_integral got;
        t_integral want;
        in_accepted = i_rst_n && smp_if.valid && smp_if.ready;
        if (i_rst_n) begin
            idle_cycles = idle_cycles + 1;
            if (smp_if.valid && smp_if.ready) begin
                idle_cycles = 0;
                integrate_sample({smp_if.sample_time, smp_if.rate_x,
                                  smp_if.rate_y, smp_if.rate_z});
            end
            if (res_if.valid && res_if.ready) begin
                idle_cycles = 0;
                got = {res_if.integral_x, res_if.integral_y,
                       res_if.integral_z, res_if.span_us};
                if (expected_integrals.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected integral %h", got);
                end else begin
                    want = expected_integrals.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("integral mismatch: expected %h %h %h %h got %h %h %h %h",
                                     want.integral_x, want.integral_y, want.integral_z,
                                     want.span_us, got.integral_x, got.integral_y,
                                     got.integral_z, got.span_us);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
        end
    end

    function automatic logic [31:0] any_rate();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    task automatic add_sample(input logic [63:0] t, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z);
        pending_samples.push_back({t, x, y, z});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_INTERVAL) gold_interval = val;
        else gold_coning = val[0];
    endtask

    // let every queued sample go and every integral arrive
    task automatic drain();
        send_enable = 1'b1;
        while (!timed_out && (pending_samples.size() > 0 || smp_if.valid
                              || expected_integrals.size() > 0))
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random phase: a mostly increasing stream with occasional backward steps and jumps
    task automatic random_phase(input int count, input logic [63:0] start);
        logic [63:0] t;
        t = start;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0: t = t - $urandom_range(1, 500);
                1: t = t + $urandom_range(32'h0100_0000, 32'h0400_0000);
                2: t = {$urandom(), $urandom()};
                default: t = t + $urandom_range(0, 3000);
            endcase
            add_sample(t, any_rate(), any_rate(), any_rate());
        end
    endtask

    initial begin
        gold_reset();
        mismatch_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        send_enable = 1'b1;
        in_accepted = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        stall_period = 8;
        stall_len = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_INTERVAL;
        i_cfg_data = '0;
        smp_if.valid = 1'b0;
        smp_if.sample_time = '0;
        smp_if.rate_x = '0;
        smp_if.rate_y = '0;
        smp_if.rate_z = '0;
        res_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: output disabled, first sample at time zero, then extremes
        add_sample(64'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
        add_sample(64'd100, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        add_sample(64'd300, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        drain();
        write_reg(CFG_INTERVAL, 32'd1);
        write_reg(CFG_CONING, 32'd1);
        add_sample(64'd400, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        add_sample(64'd350, 32'h0001_0000, 32'hffff_0000, 32'h0);
        add_sample(64'd350 + 64'h0100_0000 + 5, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        add_sample(64'hffff_ffff_ffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        add_sample(64'hffff_ffff_ffff_fff0, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678);
        add_sample(64'd1000, 32'h0000_8000, 32'hffff_8000, 32'h0000_0001);
        drain();
        write_reg(CFG_INTERVAL, 32'hffff_ffff);
        add_sample(64'd2000, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
        add_sample(64'd9000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        add_sample(64'd9001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

        // pause the sender until the block has caught up
        send_enable = 1'b0;
        while (!timed_out && expected_integrals.size() > 0) @(posedge i_clk);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 8 && !timed_out; ph++) begin
            case (ph % 4)
                0: write_reg(CFG_INTERVAL, $urandom_range(1, 5000));
                1: write_reg(CFG_INTERVAL, 32'd1);
                2: write_reg(CFG_INTERVAL, ph == 2 ? 32'd0 : $urandom());
                default: write_reg(CFG_INTERVAL, $urandom_range(2000, 20000));
            endcase
            write_reg(CFG_CONING, ph[0] ? 32'hffff_fffe : 32'd1);
            random_phase(125, gold_last_time + 1);
            drain();
        end

        if (timed_out || mismatch_count != 0 || expected_integrals.size() != 0) begin
            $display("*** FAILED ***");
        end else begin
            $display("*** PASSED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        wait (timed_out);
        $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
